@@ design/dof_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP option finder package
// Region sizes, option codes, walk phases and result kinds shared by the
// option finder and its checker.
// ----------------------------------------------------------------------------
package dof_pkg;

  localparam int OPTIONS_BYTES = 308;
  localparam int FILE_BYTES    = 128;
  localparam int SNAME_BYTES   = 64;

  localparam int POS_W = 10;
  localparam int SUM_W = POS_W + 1;

  localparam logic [7:0] PAD_CODE      = 8'd0;
  localparam logic [7:0] OVERLOAD_CODE = 8'd52;
  localparam logic [7:0] END_CODE      = 8'd255;

  localparam logic [1:0] REGION_OPTIONS = 2'd0;
  localparam logic [1:0] REGION_FILE    = 2'd1;
  localparam logic [1:0] REGION_SNAME   = 2'd2;

  localparam int FLAG_FILE  = 0;
  localparam int FLAG_SNAME = 1;

  typedef enum logic [1:0] {
    PH_DONE  = 2'd0,
    PH_CODE  = 2'd1,
    PH_LEN   = 2'd2,
    PH_VALUE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    K_DATA  = 2'd0,
    K_EMPTY = 2'd1,
    K_NONE  = 2'd2,
    K_BAD   = 2'd3
  } kind_t;

  function automatic logic [SUM_W-1:0] region_size(input logic [1:0] rgn);
    logic [SUM_W-1:0] sz;
    if (rgn == REGION_FILE) begin
      sz = SUM_W'(FILE_BYTES);
    end else if (rgn == REGION_SNAME) begin
      sz = SUM_W'(SNAME_BYTES);
    end else begin
      sz = SUM_W'(OPTIONS_BYTES);
    end
    return sz;
  endfunction

endpackage
`default_nettype wire

@@ design/dof_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP option finder channels
// Valid/ready channels for packet bytes in and option results out.
// ----------------------------------------------------------------------------
interface dof_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_packet;
  logic [1:0] region;
  logic [7:0] byte_value;
  logic [7:0] wanted_code;

  modport source (output valid, start_of_packet, region, byte_value, wanted_code,
                  input ready);
  modport sink   (input valid, start_of_packet, region, byte_value, wanted_code,
                  output ready);
endinterface

interface dof_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] option_length;
  logic       is_last;

  modport source (output valid, kind, data_byte, option_length, is_last,
                  input ready);
  modport sink   (input valid, kind, data_byte, option_length, is_last,
                  output ready);
endinterface
`default_nettype wire

@@ design/dhcp_option_finder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP option finder
// Walks the option list of the options, file and sname regions for one code
// and streams out the match's value bytes or an empty/not-found/bad mark.
// ----------------------------------------------------------------------------
// An accepted byte request is held in the input register; any result it
// gives is then registered in the result register when that is free.
// Throughput: one byte request per cycle while results are taken; the input
// and result registers admit a new request while a result waits to be taken.
// Reset: synchronous; the walk is finished and both registers are empty.
module dhcp_option_finder_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  dof_in_if.sink     request,
  dof_out_if.source  result
);

  logic       in_valid;
  logic       in_sop;
  logic [1:0] in_region;
  logic [7:0] in_byte;
  logic [7:0] in_wanted;

  dof_pkg::phase_t            walk_phase, walk_phase_next;
  logic [1:0]                 scan_region, scan_region_next;
  logic [dof_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]                 bytes_left, bytes_left_next;
  logic [7:0]                 current_code, current_code_next;
  logic [1:0]                 overload_flags, overload_flags_next;
  logic [7:0]                 target_code, target_code_next;
  logic                       matched, matched_next;
  logic [7:0]                 option_len, option_len_next;

  logic            res_valid;
  dof_pkg::kind_t  res_kind;
  logic [7:0]      res_data;
  logic [7:0]      res_len;
  logic            res_last;

  logic            out_valid;
  dof_pkg::kind_t  out_kind;
  logic [7:0]      out_data;
  logic [7:0]      out_len;
  logic            out_last;

  logic advance;

  assign advance       = in_valid && (!out_valid || result.ready);
  assign request.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (request.ready) begin
      in_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      in_sop    <= request.start_of_packet;
      in_region <= request.region;
      in_byte   <= request.byte_value;
      in_wanted <= request.wanted_code;
    end
  end

  always_comb begin
    logic [dof_pkg::SUM_W-1:0] sz;
    logic [dof_pkg::SUM_W-1:0] pos_ext;
    logic                      next_code_bad;
    logic                      overrun;

    walk_phase_next     = walk_phase;
    scan_region_next    = scan_region;
    byte_position_next  = byte_position;
    bytes_left_next     = bytes_left;
    current_code_next   = current_code;
    overload_flags_next = overload_flags;
    target_code_next    = target_code;
    matched_next        = matched;
    option_len_next     = option_len;

    res_valid = 1'b0;
    res_kind  = dof_pkg::K_NONE;
    res_data  = 8'd0;
    res_len   = 8'd0;
    res_last  = 1'b0;

    if (in_sop) begin
      target_code_next    = in_wanted;
      walk_phase_next     = dof_pkg::PH_CODE;
      scan_region_next    = dof_pkg::REGION_OPTIONS;
      byte_position_next  = '0;
      bytes_left_next     = 8'd0;
      current_code_next   = 8'd0;
      overload_flags_next = 2'd0;
      matched_next        = 1'b0;
      option_len_next     = 8'd0;
    end

    sz            = dof_pkg::region_size(scan_region_next);
    pos_ext       = {1'b0, byte_position_next};
    next_code_bad = (pos_ext + dof_pkg::SUM_W'(3)) >= sz;
    overrun       = (pos_ext + {3'b000, in_byte}) >= sz;

    if (walk_phase_next != dof_pkg::PH_DONE && in_region == scan_region_next) begin
      byte_position_next = byte_position_next + dof_pkg::POS_W'(1);
      unique case (walk_phase_next)
        dof_pkg::PH_CODE: begin
          current_code_next = in_byte;
          if (in_byte == target_code_next) begin
            matched_next    = 1'b1;
            walk_phase_next = dof_pkg::PH_LEN;
          end else if (in_byte == dof_pkg::PAD_CODE) begin
            if (next_code_bad) begin
              walk_phase_next = dof_pkg::PH_DONE;
              res_valid       = 1'b1;
              res_kind        = dof_pkg::K_BAD;
              res_last        = 1'b1;
            end
          end else if (in_byte == dof_pkg::END_CODE) begin
            if (scan_region_next == dof_pkg::REGION_OPTIONS &&
                overload_flags_next[dof_pkg::FLAG_FILE]) begin
              scan_region_next   = dof_pkg::REGION_FILE;
              byte_position_next = '0;
            end else if (scan_region_next != dof_pkg::REGION_SNAME &&
                         overload_flags_next[dof_pkg::FLAG_SNAME]) begin
              scan_region_next   = dof_pkg::REGION_SNAME;
              byte_position_next = '0;
            end else begin
              walk_phase_next = dof_pkg::PH_DONE;
              res_valid       = 1'b1;
              res_kind        = dof_pkg::K_NONE;
              res_last        = 1'b1;
            end
          end else begin
            walk_phase_next = dof_pkg::PH_LEN;
          end
        end
        dof_pkg::PH_LEN: begin
          if (overrun) begin
            walk_phase_next = dof_pkg::PH_DONE;
            res_valid       = 1'b1;
            res_kind        = dof_pkg::K_BAD;
            res_last        = 1'b1;
          end else begin
            option_len_next = in_byte;
            bytes_left_next = in_byte;
            if (in_byte == 8'd0) begin
              if (matched_next) begin
                walk_phase_next = dof_pkg::PH_DONE;
                res_valid       = 1'b1;
                res_kind        = dof_pkg::K_EMPTY;
                res_last        = 1'b1;
              end else if (next_code_bad) begin
                walk_phase_next = dof_pkg::PH_DONE;
                res_valid       = 1'b1;
                res_kind        = dof_pkg::K_BAD;
                res_last        = 1'b1;
              end else begin
                walk_phase_next = dof_pkg::PH_CODE;
              end
            end else begin
              walk_phase_next = dof_pkg::PH_VALUE;
            end
          end
        end
        dof_pkg::PH_VALUE: begin
          if (!matched_next && current_code_next == dof_pkg::OVERLOAD_CODE &&
              bytes_left_next == option_len_next) begin
            overload_flags_next = in_byte[1:0];
          end
          bytes_left_next = bytes_left_next - 8'd1;
          if (matched_next) begin
            res_valid = 1'b1;
            res_kind  = dof_pkg::K_DATA;
            res_data  = in_byte;
            res_len   = option_len_next;
            if (bytes_left_next == 8'd0) begin
              walk_phase_next = dof_pkg::PH_DONE;
              res_last        = 1'b1;
            end
          end else if (bytes_left_next == 8'd0) begin
            if (next_code_bad) begin
              walk_phase_next = dof_pkg::PH_DONE;
              res_valid       = 1'b1;
              res_kind        = dof_pkg::K_BAD;
              res_last        = 1'b1;
            end else begin
              walk_phase_next = dof_pkg::PH_CODE;
            end
          end
        end
        dof_pkg::PH_DONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_phase     <= dof_pkg::PH_DONE;
      scan_region    <= dof_pkg::REGION_OPTIONS;
      byte_position  <= '0;
      bytes_left     <= 8'd0;
      current_code   <= 8'd0;
      overload_flags <= 2'd0;
      target_code    <= 8'd0;
      matched        <= 1'b0;
      option_len     <= 8'd0;
    end else if (advance) begin
      walk_phase     <= walk_phase_next;
      scan_region    <= scan_region_next;
      byte_position  <= byte_position_next;
      bytes_left     <= bytes_left_next;
      current_code   <= current_code_next;
      overload_flags <= overload_flags_next;
      target_code    <= target_code_next;
      matched        <= matched_next;
      option_len     <= option_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.ready || !out_valid) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind <= res_kind;
      out_data <= res_data;
      out_len  <= res_len;
      out_last <= res_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_kind;
  assign result.data_byte     = out_data;
  assign result.option_length = out_len;
  assign result.is_last       = out_last;

endmodule
`default_nettype wire

@@ design/dof_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP option finder checker
// Port-level properties of the option finder, attached to every instance.
// ----------------------------------------------------------------------------
module dof_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [1:0] res_kind,
  input wire logic [7:0] res_data,
  input wire logic [7:0] res_len,
  input wire logic       res_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
      $stable(res_data) && $stable(res_len) && $stable(res_last))
    else $error("Stalled result changed.");

  a_final_kinds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != dof_pkg::K_DATA |-> res_last && res_data == 8'd0)
    else $error("Non-data result not marked last or carries data.");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == dof_pkg::K_NONE || res_kind == dof_pkg::K_BAD ||
      res_kind == dof_pkg::K_EMPTY) |-> res_len == 8'd0)
    else $error("Length reported without a nonempty match.");

  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid && !res_ready)
    else $error("Request refused while the result side was free.");

endmodule

bind dhcp_option_finder_unit dof_checker u_dof_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (request.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_kind  (result.kind),
  .res_data  (result.data_byte),
  .res_len   (result.option_length),
  .res_last  (result.is_last)
);
`default_nettype wire
